>>> hdl/frp_pkg.sv
// ---------------------------------------------------------------------------
// frp_pkg: shared types and constants for the fragment range placer
// Payload structs for both channels, job status codes, register indexes
// and the per-job state record passed between the top level and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package frp_pkg;

    localparam int DATA_W              = 64;
    localparam int TAG_W               = 8;
    localparam int SKIP_W              = 9;
    localparam int CFG_INDEX_W         = 2;
    localparam int SECTOR_BYTES_DEFAULT = 512;

    typedef enum logic [2:0] {
        ST_RUNNING  = 3'd0,
        ST_DONE     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_LIST_BIG = 3'd4,
        ST_PAST_END = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_OFFSET = 2'd0,
        CFG_RANGE_LENGTH = 2'd1,
        CFG_RUN_KIND     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [DATA_W-1:0] fragment_first_sector;
        logic [DATA_W-1:0] fragment_sectors;
        logic              last_fragment;
    } frag_t;

    typedef struct packed {
        logic              run_valid;
        logic [DATA_W-1:0] run_bytes;
        logic [DATA_W-1:0] run_source_sector;
        logic [SKIP_W-1:0] run_skip;
        logic [TAG_W-1:0]  run_tag;
        status_t           job_status;
        logic              job_end;
    } run_t;

    // range_end is cursor + bytes_left, one bit wider so it never wraps
    typedef struct packed {
        logic [DATA_W-1:0] cursor;
        logic [DATA_W-1:0] bytes_left;
        logic [DATA_W:0]   range_end;
        logic [DATA_W-1:0] base;
        status_t           phase;
    } job_state_t;

endpackage

`default_nettype wire

>>> hdl/fragment_range_placer_core.sv
// ---------------------------------------------------------------------------
// fragment_range_placer_core: maps a file byte range onto its fragment list
//
// Configure start_offset, range_length and run_kind through the cfg port
// (cfg_valid/cfg_ready, cfg_index, cfg_data) while no job is in flight;
// cfg_ready is always high. start_offset and range_length are latched at the
// first fragment of a job, so writes during a job apply to the next one;
// run_kind is copied into every run as currently written.
// Fragments enter on s_valid/s_ready as s_data; each gives exactly one
// result on m_valid/m_ready as m_data, with a run when it overlaps the
// range, and the job status. The fragment marked last closes the job.
// Each fragment passes an input register, then the placement logic into the
// result register. Throughput is one fragment per cycle while m_ready holds
// high; the job state update is a single 64-bit add followed by compares
// and subtracts in parallel.
// When the receiver stalls, the result register holds and the input
// register still takes one more fragment; s_ready then drops until m_ready.
// Reset clears all valids, the configuration and the job state; the next
// fragment opens a new job.
// ---------------------------------------------------------------------------
`default_nettype none

module fragment_range_placer_core #(
    parameter int SECTOR_BYTES = frp_pkg::SECTOR_BYTES_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [frp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frp_pkg::DATA_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  frp_pkg::frag_t                  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output frp_pkg::run_t                   m_data
);
    import frp_pkg::*;

    logic [DATA_W-1:0] start_offset_reg, start_offset_next;
    logic [DATA_W-1:0] range_length_reg, range_length_next;
    logic [TAG_W-1:0]  run_kind_reg, run_kind_next;
    logic [DATA_W:0]   cfg_end_reg, cfg_end_next;

    frag_t      in_reg;
    logic       in_valid_reg, in_valid_next;
    run_t       out_reg;
    logic       out_valid_reg, out_valid_next;
    job_state_t st_reg;
    logic       job_open_reg, job_open_next;

    job_state_t st_eff;
    job_state_t st_new;
    run_t       res;
    logic       s_xfer;
    logic       advance;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_comb begin
        start_offset_next = start_offset_reg;
        range_length_next = range_length_reg;
        run_kind_next     = run_kind_reg;
        cfg_end_next      = cfg_end_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_START_OFFSET: begin
                    start_offset_next = cfg_data;
                    cfg_end_next      = {1'b0, cfg_data} + {1'b0, range_length_reg};
                end
                CFG_RANGE_LENGTH: begin
                    range_length_next = cfg_data;
                    cfg_end_next      = {1'b0, start_offset_reg} + {1'b0, cfg_data};
                end
                CFG_RUN_KIND: run_kind_next = cfg_data[TAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_offset_reg <= '0;
            range_length_reg <= '0;
            run_kind_reg     <= '0;
            cfg_end_reg      <= '0;
        end else begin
            start_offset_reg <= start_offset_next;
            range_length_reg <= range_length_next;
            run_kind_reg     <= run_kind_next;
            cfg_end_reg      <= cfg_end_next;
        end
    end

    // ---------------- handshake ----------------
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    assign in_valid_next  = s_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    assign job_open_next  = advance ? !in_reg.last_fragment : job_open_reg;

    // a new job starts from the configured range
    always_comb begin
        if (job_open_reg) begin
            st_eff = st_reg;
        end else begin
            st_eff.cursor     = start_offset_reg;
            st_eff.bytes_left = range_length_reg;
            st_eff.range_end  = cfg_end_reg;
            st_eff.base       = '0;
            st_eff.phase      = ST_RUNNING;
        end
    end

    frp_place #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_place (
        .frag     (in_reg),
        .st       (st_eff),
        .run_kind (run_kind_reg),
        .st_next  (st_new),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            job_open_reg  <= 1'b0;
            st_reg        <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            job_open_reg  <= job_open_next;
            if (advance) begin
                st_reg <= st_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ---------------- assertions ----------------
    a_run_only_while_placing: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.run_valid) |->
            (m_data.job_status == ST_RUNNING || m_data.job_status == ST_DONE ||
             m_data.job_status == ST_PAST_END))
        else $error("run emitted with error status");

    a_idle_run_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.run_valid) |->
            (m_data.run_bytes == '0 && m_data.run_source_sector == '0 &&
             m_data.run_skip == '0 && m_data.run_tag == '0))
        else $error("non-run result carries payload");

    a_end_not_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.job_end) |-> (m_data.job_status != ST_RUNNING))
        else $error("job ended while still running");

    a_last_closes_job: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.last_fragment) |=> !job_open_reg)
        else $error("job still open after last fragment");

endmodule

`default_nettype wire

>>> hdl/frp_place.sv
// ---------------------------------------------------------------------------
// frp_place: fragment placement datapath
// Checks one fragment against the job state, cuts the overlapping run and
// produces the next job state. Pure combinational, one fragment per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module frp_place #(
    parameter int SECTOR_BYTES = frp_pkg::SECTOR_BYTES_DEFAULT
) (
    input  frp_pkg::frag_t                  frag,
    input  frp_pkg::job_state_t             st,
    input  logic [frp_pkg::TAG_W-1:0]       run_kind,
    output frp_pkg::job_state_t             st_next,
    output frp_pkg::run_t                   res
);
    import frp_pkg::*;

    localparam int SHIFT = $clog2(SECTOR_BYTES);

    logic [DATA_W-1:0] span_bytes;
    logic [DATA_W:0]   span_stop;
    logic [DATA_W:0]   rem_wide;
    logic [DATA_W-1:0] take;
    logic [DATA_W-1:0] sector;
    logic [DATA_W-1:0] skip_wide;
    logic              too_big;
    logic              list_big;
    logic              left_nz;
    logic              hit;
    logic              short_range;
    logic              fits_end;

    assign too_big    = (frag.fragment_sectors >> (DATA_W - SHIFT)) != '0;
    assign span_bytes = frag.fragment_sectors << SHIFT;
    assign span_stop  = {1'b0, st.base} + {1'b0, span_bytes};
    assign list_big   = span_stop[DATA_W];

    assign left_nz     = st.bytes_left != '0;
    assign hit         = left_nz && (st.cursor < span_stop[DATA_W-1:0]);
    // range ends inside this fragment: the run takes everything left
    assign short_range = st.range_end < span_stop;
    assign fits_end    = st.range_end <= span_stop;
    assign rem_wide    = st.range_end - span_stop;

    assign take = short_range ? st.bytes_left : (span_stop[DATA_W-1:0] - st.cursor);

    // base is sector aligned, so the sector index splits without a borrow
    assign sector    = frag.fragment_first_sector + (st.cursor >> SHIFT) - (st.base >> SHIFT);
    assign skip_wide = st.cursor & (DATA_W'(SECTOR_BYTES) - DATA_W'(1));

    always_comb begin
        st_next = st;
        res     = '0;
        if (st.phase == ST_RUNNING) begin
            priority if (frag.fragment_sectors == '0) begin
                st_next.phase = ST_EMPTY;
            end else if (too_big) begin
                st_next.phase = ST_TOO_BIG;
            end else if (list_big) begin
                st_next.phase = ST_LIST_BIG;
            end else begin
                if (hit) begin
                    res.run_valid         = 1'b1;
                    res.run_bytes         = take;
                    res.run_source_sector = sector;
                    res.run_skip          = skip_wide[SKIP_W-1:0];
                    res.run_tag           = run_kind;
                    st_next.cursor        = short_range ? st.range_end[DATA_W-1:0]
                                                        : span_stop[DATA_W-1:0];
                    st_next.bytes_left    = short_range ? '0 : rem_wide[DATA_W-1:0];
                end
                st_next.base = span_stop[DATA_W-1:0];
                if (hit ? fits_end : !left_nz) begin
                    st_next.phase = ST_DONE;
                end
            end
        end
        if (frag.last_fragment && st_next.phase == ST_RUNNING) begin
            st_next.phase = ST_PAST_END;
        end
        res.job_status = st_next.phase;
        res.job_end    = frag.last_fragment;
    end

endmodule

`default_nettype wire

>>> tb/fragment_range_placer_core_tb.sv
// ---------------------------------------------------------------------------
// fragment_range_placer_core_tb: self-checking bench for the range placer
// A directed table (reset values, range extremes, each error code, sticky
// status, register writes in the middle of a job) is followed by random
// fragment lists under random configuration. Each result is checked field by
// field against the table's value if given, else a cycle-free placement model.
// ---------------------------------------------------------------------------

module fragment_range_placer_core_tb;

    import frp_pkg::*;

    localparam int          SECTOR_BYTES  = SECTOR_BYTES_DEFAULT;
    localparam logic [63:0] SECTOR_SIZE   = 64'(SECTOR_BYTES);
    localparam logic [63:0] MAX_SECTORS   = 64'hFFFF_FFFF_FFFF_FFFF / SECTOR_SIZE;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int          RANDOM_ITEMS  = 800;
    localparam int          IDLE_PCT      = 6;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          HOLD_PHASE    = 5;
    localparam int          HOLD_CYCLES   = 120;
    localparam int          STALL_LIMIT   = 2000;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] index;
        logic [63:0]            value;
        frag_t                  frag;
        bit                     typed;
        run_t                   want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DATA_W-1:0]      cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    frag_t                  s_data;
    logic                   m_valid;
    logic                   m_ready;
    run_t                   m_data;

    // placement model state
    logic [63:0] cfg_start;
    logic [63:0] cfg_length;
    logic [7:0]  cfg_kind;
    logic [63:0] list_base;
    logic [63:0] cur_pos;
    logic [63:0] remaining;
    status_t     job_phase;
    bit          job_open;

    run_t        expected_runs[$];
    stim_row_t   directed_rows[$];
    int          errors;
    int          stall_cycles;
    int          hold_left;
    bit          hold_request;
    bit          no_idle;

    fragment_range_placer_core #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic run_t place_fragment(frag_t f);
        run_t        r;
        logic [64:0] end_sum;
        logic [63:0] span_bytes;
        logic [63:0] offset_in;
        logic [63:0] room;
        logic [63:0] take;
        r = '0;
        if (!job_open) begin
            cur_pos   = cfg_start;
            remaining = cfg_length;
            list_base = '0;
            job_phase = ST_RUNNING;
            job_open  = 1'b1;
        end
        if (job_phase == ST_RUNNING) begin
            if (f.fragment_sectors == '0) begin
                job_phase = ST_EMPTY;
            end else if (f.fragment_sectors > MAX_SECTORS) begin
                job_phase = ST_TOO_BIG;
            end else begin
                span_bytes = f.fragment_sectors * SECTOR_SIZE;
                end_sum    = {1'b0, list_base} + {1'b0, span_bytes};
                if (end_sum[64]) begin
                    job_phase = ST_LIST_BIG;
                end else begin
                    if (remaining != '0 && cur_pos < end_sum[63:0]) begin
                        offset_in = cur_pos - list_base;
                        room      = end_sum[63:0] - cur_pos;
                        take      = (remaining < room) ? remaining : room;
                        r.run_valid         = 1'b1;
                        r.run_bytes         = take;
                        r.run_source_sector = f.fragment_first_sector + offset_in / SECTOR_SIZE;
                        r.run_skip          = SKIP_W'(offset_in % SECTOR_SIZE);
                        r.run_tag           = cfg_kind;
                        cur_pos   = cur_pos + take;
                        remaining = remaining - take;
                    end
                    list_base = end_sum[63:0];
                    if (remaining == '0)
                        job_phase = ST_DONE;
                end
            end
        end
        if (f.last_fragment) begin
            if (job_phase == ST_RUNNING)
                job_phase = ST_PAST_END;
            job_open = 1'b0;
        end
        r.job_status = job_phase;
        r.job_end    = f.last_fragment;
        return r;
    endfunction

    function automatic run_t run_of(logic v, logic [63:0] nbytes, logic [63:0] sector,
                                    logic [8:0] skip, logic [7:0] tag, status_t st,
                                    logic last);
        run_t r;
        r.run_valid         = v;
        r.run_bytes         = nbytes;
        r.run_source_sector = sector;
        r.run_skip          = skip;
        r.run_tag           = tag;
        r.job_status        = st;
        r.job_end           = last;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, logic [63:0] v);
        stim_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.index  = idx;
        row.value  = v;
        return row;
    endfunction

    function automatic stim_row_t frag_row(logic [63:0] first, logic [63:0] count,
                                           logic last);
        stim_row_t row;
        row = '{default: '0};
        row.frag.fragment_first_sector = first;
        row.frag.fragment_sectors      = count;
        row.frag.last_fragment         = last;
        return row;
    endfunction

    function automatic stim_row_t typed_row(logic [63:0] first, logic [63:0] count,
                                            logic last, run_t want);
        stim_row_t row;
        row       = frag_row(first, count, last);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic void add_row(stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    task automatic send_fragment(frag_t f, bit typed, run_t want);
        run_t predicted;
        @(negedge aclk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= f;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = place_fragment(f);
        expected_runs.insert(expected_runs.size(), typed ? want : predicted);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [63:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_START_OFFSET: cfg_start  = v;
            CFG_RANGE_LENGTH: cfg_length = v;
            CFG_RUN_KIND:     cfg_kind   = v[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // registers change only with nothing in flight
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        run_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_runs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
            end else begin
                want = expected_runs.pop_front();
                check_field("run_valid", want.run_valid, m_data.run_valid);
                check_field("run_bytes", want.run_bytes, m_data.run_bytes);
                check_field("run_source_sector", want.run_source_sector,
                            m_data.run_source_sector);
                check_field("run_skip", want.run_skip, m_data.run_skip);
                check_field("run_tag", want.run_tag, m_data.run_tag);
                check_field("job_status", want.job_status, m_data.job_status);
                check_field("job_end", want.job_end, m_data.job_end);
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                m_ready   <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        frag_t       f;
        logic [63:0] value;
        int          phase_no;
        int          random_items;
        int          jobs;
        int          frags;
        int          pick;
        bit          broken;

        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        errors       = 0;
        stall_cycles = 0;
        hold_left    = 0;
        hold_request = 1'b0;
        no_idle      = 1'b0;
        cfg_start    = '0;
        cfg_length   = '0;
        cfg_kind     = '0;
        list_base    = '0;
        cur_pos      = '0;
        remaining    = '0;
        job_phase    = ST_RUNNING;
        job_open     = 1'b0;

        // zero range after reset: passes the first check, then done
        add_row(typed_row(64'd100, 64'd1, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_DONE, 1)));
        add_row(typed_row(64'd100, 64'd0, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_EMPTY, 1)));
        add_row(cfg_row(CFG_START_OFFSET, 64'd0));
        add_row(cfg_row(CFG_RANGE_LENGTH, 64'd1024));
        add_row(cfg_row(CFG_RUN_KIND, 64'hA5));
        add_row(typed_row(64'd1000, 64'd1, 1'b0,
                          run_of(1, 512, 1000, 0, 8'hA5, ST_RUNNING, 0)));
        add_row(typed_row(64'd2000, 64'd4, 1'b0,
                          run_of(1, 512, 2000, 0, 8'hA5, ST_DONE, 0)));
        // range placed, remaining fragments pass through
        add_row(typed_row(64'd3000, 64'd1, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_DONE, 1)));
        add_row(typed_row(64'd0, 64'h0080_0000_0000_0000, 1'b0,
                          run_of(0, 0, 0, 0, 0, ST_TOO_BIG, 0)));
        add_row(typed_row(64'd5, 64'd0, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_TOO_BIG, 1)));
        // list ends with bytes still to place
        add_row(typed_row(64'd7, 64'd1, 1'b1,
                          run_of(1, 512, 7, 0, 8'hA5, ST_PAST_END, 1)));
        add_row(cfg_row(CFG_START_OFFSET, 64'd700));
        add_row(cfg_row(CFG_RANGE_LENGTH, 64'd10000));
        add_row(frag_row(ALL_ONES, 64'd3, 1'b0));
        add_row(typed_row(64'd0, ALL_ONES, 1'b0,
                          run_of(0, 0, 0, 0, 0, ST_TOO_BIG, 0)));
        add_row(typed_row(64'd0, 64'd1, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_TOO_BIG, 1)));
        // run at the top of the byte space, then list offset overflow
        add_row(cfg_row(CFG_START_OFFSET, 64'hFFFF_FFFF_FFFF_FC00));
        add_row(cfg_row(CFG_RANGE_LENGTH, ALL_ONES));
        add_row(cfg_row(CFG_RUN_KIND, 64'hFF));
        add_row(frag_row(ALL_ONES, MAX_SECTORS, 1'b0));
        add_row(typed_row(64'd0, 64'd1, 1'b0,
                          run_of(0, 0, 0, 0, 0, ST_LIST_BIG, 0)));
        add_row(typed_row(64'd0, 64'd1, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_LIST_BIG, 1)));
        add_row(cfg_row(CFG_START_OFFSET, ALL_ONES));
        add_row(cfg_row(CFG_RANGE_LENGTH, 64'd1));
        add_row(cfg_row(CFG_RUN_KIND, 64'h00));
        add_row(typed_row(64'd0, MAX_SECTORS, 1'b0,
                          run_of(0, 0, 0, 0, 0, ST_RUNNING, 0)));
        add_row(typed_row(64'd0, 64'd1, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_LIST_BIG, 1)));
        // unused index must leave every register alone
        add_row(cfg_row(CFG_START_OFFSET, 64'd0));
        add_row(cfg_row(CFG_UNUSED, ALL_ONES));
        add_row(typed_row(64'd50, 64'd2, 1'b1,
                          run_of(1, 1, 50, 0, 8'h00, ST_DONE, 1)));
        // range writes in the middle of a job only apply to the next job
        add_row(cfg_row(CFG_START_OFFSET, ALL_ONES));
        add_row(typed_row(64'd10, 64'd2, 1'b0,
                          run_of(0, 0, 0, 0, 0, ST_RUNNING, 0)));
        add_row(cfg_row(CFG_START_OFFSET, 64'd0));
        add_row(cfg_row(CFG_RUN_KIND, 64'h3C));
        add_row(typed_row(64'd11, 64'd1, 1'b1,
                          run_of(0, 0, 0, 0, 0, ST_PAST_END, 1)));
        add_row(typed_row(64'd9, 64'd1, 1'b1,
                          run_of(1, 1, 9, 0, 8'h3C, ST_DONE, 1)));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                wait_idle();
                cfg_write(directed_rows[i].index, directed_rows[i].value);
            end else begin
                send_fragment(directed_rows[i].frag, directed_rows[i].typed,
                              directed_rows[i].want);
            end
        end

        random_items = 0;
        phase_no     = 0;
        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 9))
                    0:       value = '0;
                    1:       value = ALL_ONES;
                    2:       value = {$urandom, $urandom};
                    3:       value = ALL_ONES - 64'($urandom_range(0, 4095));
                    default: value = 64'($urandom_range(0, 12000));
                endcase
                cfg_write(CFG_START_OFFSET, value);
            end
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 9))
                    0:       value = '0;
                    1:       value = ALL_ONES;
                    2:       value = {$urandom, $urandom};
                    default: value = 64'($urandom_range(1, 12000));
                endcase
                cfg_write(CFG_RANGE_LENGTH, value);
            end
            if ($urandom_range(0, 9) < 7)
                cfg_write(CFG_RUN_KIND, 64'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0)
                cfg_write(CFG_UNUSED, {$urandom, $urandom});
            if (phase_no == HOLD_PHASE)
                hold_request = 1'b1;

            jobs = $urandom_range(2, 5);
            for (int j = 0; j < jobs; j++) begin
                // a few lists with stray or missing last marks
                broken = ($urandom_range(0, 9) == 0);
                frags  = $urandom_range(1, 8);
                for (int k = 0; k < frags; k++) begin
                    f.fragment_first_sector = {$urandom, $urandom};
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                        f.fragment_sectors = '0;
                    else if (pick < 8)
                        f.fragment_sectors = {$urandom, $urandom};
                    else if (pick < 10)
                        f.fragment_sectors = MAX_SECTORS - 64'd1 + 64'($urandom_range(0, 2));
                    else
                        f.fragment_sectors = 64'($urandom_range(1, 12));
                    f.last_fragment = broken ? 1'($urandom_range(0, 1)) : (k == frags - 1);
                    send_fragment(f, 1'b0, '0);
                    random_items++;
                    no_idle = (random_items >= 300 && random_items < 450);
                end
            end
            phase_no++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/frp_pkg.sv
hdl/frp_place.sv
hdl/fragment_range_placer_core.sv
tb/fragment_range_placer_core_tb.sv
